@@ rtl/swrl_pkg.sv @@
// Shared types, constants and register codes for the sliding window rate limiter.
// No dependencies; every other rtl file refers to this package by scoped names.

package swrl_pkg;

  localparam int CLIENTS    = 64;
  localparam int RING_DEPTH = 8;

  localparam int CLI_AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int RP_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);

  localparam int FUNC_W   = 2;
  localparam int CLIENT_W = 6;
  localparam int TICK_W   = 32;
  localparam int LIMIT_W  = 8;
  localparam int WIN_W    = 20;
  localparam int THR_W    = 4;
  localparam int WCNT_W   = 4;
  localparam int CFG_AW   = 2;

  // operation selector
  localparam logic [FUNC_W-1:0] FN_MOVE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_VIOL = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_LIMIT  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WINDOW = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_THRESH = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 8'd8;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 20'd60;
  localparam logic [THR_W-1:0]   THRESH_RST = 4'd3;

  localparam logic [LIMIT_W-1:0] PKT_SAT = 8'hFF;

  typedef logic [TICK_W-1:0] tick_t;

  // one memory row holds everything known about a client
  typedef struct packed {
    tick_t                   last_tick;
    logic [LIMIT_W-1:0]      pkts;
    tick_t                   total;
    logic [RP_W-1:0]         wp;
    tick_t [RING_DEPTH-1:0]  ring;
  } row_t;

  // item held between acceptance and the update cycle
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CLIENT_W-1:0] client;
    logic                in_tab;
    tick_t               now;
    tick_t               stored;
    tick_t               start;
  } req_t;

  typedef struct packed {
    logic                we;
    row_t                row;
    logic                rec;
    logic [WCNT_W-1:0]   wcount;
    logic                disc;
    tick_t               total;
  } upd_t;

endpackage

@@ rtl/swrl_row_mem.sv @@
// Per-client state memory: one row per client, synchronous read, one write port.
// Per-row valid bits make unwritten rows read as zero after reset. Uses swrl_pkg.

module swrl_row_mem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [swrl_pkg::CLI_AW-1:0] rd_addr,
  output swrl_pkg::row_t             rd_row,
  input  logic                       wr_en,
  input  logic [swrl_pkg::CLI_AW-1:0] wr_addr,
  input  swrl_pkg::row_t             wr_row
);

  swrl_pkg::row_t                 mem [swrl_pkg::CLIENTS];
  logic [swrl_pkg::CLIENTS-1:0]   valid_r;
  swrl_pkg::row_t                 rdata_r;
  logic                           rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_row = rvld_r ? rdata_r : '0;

endmodule

@@ rtl/swrl_update.sv @@
// Read-modify-write logic for one client row: packet counting, violation ring,
// window count and disconnect decision. Uses swrl_pkg.

module swrl_update (
  input  swrl_pkg::req_t                    req,
  input  swrl_pkg::row_t                    row_in,
  input  logic [swrl_pkg::LIMIT_W-1:0]      limit,
  input  logic [swrl_pkg::THR_W-1:0]        thresh,
  output swrl_pkg::upd_t                    upd
);

  localparam int RING_DEPTH_L = swrl_pkg::RING_DEPTH;

  logic                           new_tick;
  logic [swrl_pkg::LIMIT_W-1:0]   pk0;
  logic [swrl_pkg::LIMIT_W-1:0]   pk1;
  logic                           burst;
  logic [RING_DEPTH_L-1:0]        hit;
  logic                           hit_st;
  logic [swrl_pkg::CNT_W-1:0]     cnt;
  logic [swrl_pkg::RP_W-1:0]      wp_inc;
  logic                           rec;
  swrl_pkg::row_t                 row_out;
  logic                           we;

  assign new_tick = row_in.last_tick != req.now;
  assign pk0      = new_tick ? '0 : row_in.pkts;
  assign pk1      = (pk0 != swrl_pkg::PKT_SAT) ? pk0 + 1'b1 : pk0;
  assign burst    = {1'b0, pk1} == ({1'b0, limit} + 9'd1);

  assign wp_inc = (row_in.wp == swrl_pkg::RP_W'(RING_DEPTH_L - 1)) ? '0 : row_in.wp + 1'b1;

  // window hits of the old entries; the slot at wp gets the new time instead
  always_comb begin
    for (int i = 0; i < RING_DEPTH_L; i++) begin
      hit[i] = (row_in.ring[i] >= req.start) && (row_in.ring[i] <= req.stored);
    end
  end

  assign hit_st = req.stored >= req.start;

  always_comb begin
    cnt = swrl_pkg::CNT_W'(hit_st);
    for (int i = 0; i < RING_DEPTH_L; i++) begin
      if (swrl_pkg::RP_W'(i) != row_in.wp) begin
        cnt = cnt + swrl_pkg::CNT_W'(hit[i]);
      end
    end
  end

  always_comb begin
    row_out = row_in;
    we      = 1'b0;
    rec     = 1'b0;
    if (req.in_tab) begin
      unique case (req.func)
        swrl_pkg::FN_MOVE: begin
          we                = 1'b1;
          row_out.last_tick = req.now;
          row_out.pkts      = pk1;
          rec               = burst;
        end
        swrl_pkg::FN_VIOL: begin
          rec = 1'b1;
        end
        swrl_pkg::FN_CLR: begin
          we      = 1'b1;
          row_out = '0;
        end
        default: begin
          we = 1'b0;
        end
      endcase
      if (rec) begin
        we                     = 1'b1;
        row_out.total          = row_in.total + 1'b1;
        row_out.ring[row_in.wp] = req.stored;
        row_out.wp             = wp_inc;
      end
    end
  end

  always_comb begin
    upd.we     = we;
    upd.row    = row_out;
    upd.rec    = rec;
    upd.wcount = '0;
    upd.disc   = 1'b0;
    upd.total  = req.in_tab ? row_out.total : '0;
    if (rec) begin
      upd.wcount = (32'(cnt) > 32'd15) ? 4'd15 : swrl_pkg::WCNT_W'(32'(cnt));
      upd.disc   = 32'(cnt) >= 32'(thresh);
    end
  end

endmodule

@@ rtl/sliding_window_rate_limiter_top.sv @@
// Top level of the per-client sliding window rate limiter: handshakes, config
// registers, control sequencer and output register. Uses swrl_pkg, swrl_row_mem, swrl_update.
//
//  channel   dir  signals                 payload
//  in_       in   tvalid tready tdata     tdata: client[5:0] now_tick[37:6]; tuser: func[1:0]
//  out_      out  tvalid tready tdata     tdata: client_out, violation_recorded, window_count,
//                                                disconnect, total_violations
//  cfg_      in   we addr wdata           register index in addr, value in wdata
//
// In ST_IDLE an accepted item starts the read of the client's row from the state
// memory; in ST_EXEC the update is computed, the row is written back and the output
// register is loaded. A full output register that is not taken holds ST_EXEC.
// Reset is synchronous; per-row valid bits clear at once, so there is no clearing pass.

module sliding_window_rate_limiter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // client[5:0], now_tick[37:6], zero[39:38]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // client_out[5:0], violation_recorded[6], window_count[10:7],
                                  // disconnect[11], total_violations[43:12], zero[47:44]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [19:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                          st_r, st_nxt;
  logic [swrl_pkg::LIMIT_W-1:0]    limit_r;
  logic [swrl_pkg::WIN_W-1:0]      window_r;
  logic [swrl_pkg::THR_W-1:0]      thresh_r;
  swrl_pkg::req_t                  req_r, req_nxt;
  swrl_pkg::row_t                  rd_row;
  swrl_pkg::upd_t                  upd;
  logic                            accept;
  logic                            exec_go;
  logic                            mem_we;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [47:0]                     out_tdata_r;
  logic [swrl_pkg::CLIENT_W-1:0]   in_client;
  swrl_pkg::tick_t                 in_now;

  assign in_client = in_tdata[5:0];
  assign in_now    = in_tdata[37:6];

  assign in_tready = st_r == ST_IDLE;
  assign accept    = in_tvalid && in_tready;
  assign exec_go   = (st_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  assign mem_we    = exec_go && upd.we;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= swrl_pkg::LIMIT_RST;
      window_r <= swrl_pkg::WINDOW_RST;
      thresh_r <= swrl_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        swrl_pkg::CFG_LIMIT:  limit_r  <= cfg_wdata[7:0];
        swrl_pkg::CFG_WINDOW: window_r <= cfg_wdata;
        swrl_pkg::CFG_THRESH: thresh_r <= cfg_wdata[3:0];
        default: begin
          limit_r <= limit_r;
        end
      endcase
    end
  end

  // window bounds are worked out while the row is being read
  always_comb begin
    req_nxt        = req_r;
    if (accept) begin
      req_nxt.func   = in_tuser;
      req_nxt.client = in_client;
      req_nxt.in_tab = 32'(in_client) < 32'(swrl_pkg::CLIENTS);
      req_nxt.now    = in_now;
      req_nxt.stored = in_now + 32'd1;
      req_nxt.start  = (in_now >= 32'(window_r)) ? in_now - 32'(window_r) + 32'd1 : 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (accept) st_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (exec_go) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_tdata_r <= {4'd0, upd.total, upd.disc, upd.wcount, upd.rec, req_r.client};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  swrl_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (swrl_pkg::CLI_AW'(in_client)),
    .rd_row  (rd_row),
    .wr_en   (mem_we),
    .wr_addr (swrl_pkg::CLI_AW'(req_r.client)),
    .wr_row  (upd.row)
  );

  swrl_update u_upd (
    .req    (req_r),
    .row_in (rd_row),
    .limit  (limit_r),
    .thresh (thresh_r),
    .upd    (upd)
  );

`ifndef SYNTHESIS
  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // a disconnect is only ever reported together with a recorded violation
  a_disc_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[6])
    else $error("disconnect without a recorded violation");

  // row write-back only when its result can be loaded
  a_we_out: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!out_tvalid_r || out_tready) && st_r == ST_EXEC)
    else $error("state written back while output is blocked");

  // every update cycle that finishes leaves a valid result behind
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_tvalid && st_r == ST_IDLE)
    else $error("finished item did not produce a result");
`endif

endmodule

@@ bench/tb_sliding_window_rate_limiter_top.sv @@
// Self-checking bench for sliding_window_rate_limiter_top: directed and random policing
// requests, an in-bench per-client model of the limiter, and field-by-field result checks.
// Depends on swrl_pkg and the rtl top level only.
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter_top;
  import swrl_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;  // unused code, must leave state alone
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLDOFF_AT  = 700;
  localparam int HOLDOFF_LEN = 250;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [CLIENT_W-1:0] client;
    tick_t               tick;
  } request_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] client;
    logic                rec;
    logic [WCNT_W-1:0]   wcount;
    logic                disc;
    tick_t               total;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // client[5:0], now_tick[37:6], zero[39:38]
  logic [1:0]  in_tuser = '0;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // client_out[5:0], violation_recorded[6], window_count[10:7],
                                // disconnect[11], total_violations[43:12], zero[47:44]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [19:0] cfg_wdata = '0;

  sliding_window_rate_limiter_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state of the limiter
  logic [LIMIT_W-1:0] lim_q;
  logic [WIN_W-1:0]   win_q;
  logic [THR_W-1:0]   thr_q;
  tick_t              last_tick [CLIENTS];
  logic [7:0]         pkt_cnt [CLIENTS];
  tick_t              viol_total [CLIENTS];
  tick_t              viol_ring [CLIENTS][RING_DEPTH];
  int                 ring_wp [CLIENTS];

  request_t policing_reqs[$];
  verdict_t expected_verdicts[$];
  request_t cur_req;
  bit       calm = 1'b0;        // no idling on either side while set
  int       errors = 0;
  int       results_seen = 0;
  int       viol_seen = 0;
  int       disc_seen = 0;
  int       quiet = 0;
  int       stall_left = 0;
  bit       holdoff_done = 1'b0;

  function automatic void clear_client(int c);
    last_tick[c]  = '0;
    pkt_cnt[c]    = '0;
    viol_total[c] = '0;
    ring_wp[c]    = 0;
    for (int i = 0; i < RING_DEPTH; i++) viol_ring[c][i] = '0;
  endfunction

  function automatic verdict_t police_item(request_t rq);
    verdict_t v;
    tick_t    stored, start;
    int       hits;
    int       c;
    logic     rec;
    v = '0;
    c = rq.client;
    rec = 1'b0;
    v.client = rq.client;
    case (rq.func)
      FN_MOVE: begin
        if (last_tick[c] != rq.tick) begin
          last_tick[c] = rq.tick;
          pkt_cnt[c] = '0;
        end
        if (pkt_cnt[c] != PKT_SAT) pkt_cnt[c] = pkt_cnt[c] + 8'd1;
        rec = (int'(pkt_cnt[c]) == int'(lim_q) + 1);
      end
      FN_VIOL: rec = 1'b1;
      FN_CLR:  clear_client(c);
      default: ;
    endcase
    if (rec) begin
      stored = rq.tick + 32'd1;
      start = (rq.tick >= tick_t'(win_q)) ? rq.tick - tick_t'(win_q) + 32'd1 : 32'd1;
      viol_total[c] = viol_total[c] + 32'd1;
      viol_ring[c][ring_wp[c]] = stored;
      ring_wp[c] = (ring_wp[c] + 1) % RING_DEPTH;
      hits = 0;
      for (int i = 0; i < RING_DEPTH; i++)
        if (viol_ring[c][i] >= start && viol_ring[c][i] <= stored) hits++;
      v.rec    = 1'b1;
      v.wcount = (hits > 15) ? 4'd15 : WCNT_W'(hits);
      v.disc   = (hits >= int'(thr_q));
    end
    v.total = viol_total[c];
    return v;
  endfunction

  // sender: one request in flight on the bus, refilled from policing_reqs
  always @(posedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_verdicts.push_back(police_item(cur_req));
      if (!in_tvalid || in_tready) begin
        if (policing_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 17)) begin
          nxt = policing_reqs.pop_front();
          cur_req   <= nxt;
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, nxt.tick, nxt.client};
          in_tuser  <= nxt.func;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      stall_left <= HOLDOFF_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.client = out_tdata[5:0];
      got.rec    = out_tdata[6];
      got.wcount = out_tdata[10:7];
      got.disc   = out_tdata[11];
      got.total  = out_tdata[43:12];
      results_seen <= results_seen + 1;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("client_out", 32'(want.client), 32'(got.client));
        check_field("violation_recorded", 32'(want.rec), 32'(got.rec));
        check_field("window_count", 32'(want.wcount), 32'(got.wcount));
        check_field("disconnect", 32'(want.disc), 32'(got.disc));
        check_field("total_violations", want.total, got.total);
        if (want.rec) viol_seen++;
        if (want.disc) disc_seen++;
      end
    end
  end

  // watchdog: cycles with work outstanding but no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (policing_reqs.size() == 0 && !in_tvalid && expected_verdicts.size() == 0))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet, expected_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [19:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LIMIT:  lim_q = val[LIMIT_W-1:0];
      CFG_WINDOW: win_q = val[WIN_W-1:0];
      CFG_THRESH: thr_q = val[THR_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_policy(int lim, int win, int thr);
    write_reg(CFG_LIMIT, 20'(lim));
    write_reg(CFG_WINDOW, 20'(win));
    write_reg(CFG_THRESH, 20'(thr));
  endtask

  task automatic push_req(logic [FUNC_W-1:0] f, int c, tick_t t);
    request_t rq;
    rq.func = f;
    rq.client = CLIENT_W'(c);
    rq.tick = t;
    policing_reqs.push_back(rq);
  endtask

  // waits until every queued request is sent and every outstanding result is in
  task automatic drain();
    while (policing_reqs.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [FUNC_W-1:0] FN_FUNC_RAND();
    return FUNC_W'($urandom_range(0, 3));
  endfunction

  // mostly traffic on a few busy clients around a slowly moving tick, some noise
  task automatic queue_random(int n, tick_t base);
    tick_t cur;
    int    busy [3];
    int    r;
    int    c;
    cur = base;
    for (int i = 0; i < 3; i++) busy[i] = $urandom_range(0, CLIENTS - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) cur = cur + $urandom_range(1, 3);
      if ($urandom_range(0, 49) == 0) cur = cur + $urandom_range(0, 2 * int'(win_q));
      c = busy[$urandom_range(0, 2)];
      r = $urandom_range(0, 99);
      if (r < 60)
        push_req(FN_MOVE, c, cur);
      else if (r < 80)
        push_req(FN_VIOL, c, cur - $urandom_range(0, 4));
      else if (r < 84)
        push_req(FN_CLR, c, cur);
      else if (r < 88)
        push_req(FN_SPARE, c, cur);
      else
        push_req(FN_FUNC_RAND(), $urandom_range(0, CLIENTS - 1), $urandom());
    end
  endtask

  initial begin
    for (int c = 0; c < CLIENTS; c++) clear_client(c);
    lim_q = LIMIT_RST;
    win_q = WINDOW_RST;
    thr_q = THRESH_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset policy: external reports, tick wrap, spare code, client clear, burst
    push_req(FN_VIOL, 63, 32'd0);
    push_req(FN_VIOL, 63, 32'd59);
    push_req(FN_VIOL, 63, 32'hFFFF_FFFF);
    push_req(FN_SPARE, 63, 32'd5);
    push_req(FN_VIOL, 63, 32'd60);
    push_req(FN_CLR, 63, 32'd60);
    push_req(FN_SPARE, 63, 32'd61);
    for (int i = 0; i < 10; i++) push_req(FN_MOVE, 1, 32'hAAAA_AAAA);
    push_req(FN_MOVE, 1, 32'h5555_5555);
    drain();

    // tightest policy: the first packet of a tick already violates
    set_policy(0, 1, 1);
    push_req(FN_MOVE, 2, 32'd7);
    push_req(FN_MOVE, 2, 32'd7);
    push_req(FN_VIOL, 2, 32'd7);
    push_req(FN_VIOL, 0, 32'd8);
    drain();

    set_policy(2, 16, 2);
    queue_random(220, 32'd0);
    drain();

    // loose policy with the widest window near the tick wrap, no idling
    calm = 1'b1;
    set_policy(254, 1048575, 8);
    queue_random(200, 32'hFFFF_FFC0);
    drain();
    calm = 1'b0;

    set_policy(0, 1, 1);
    queue_random(200, $urandom());
    drain();

    set_policy($urandom_range(0, 6), $urandom_range(1, 200), $urandom_range(1, 8));
    queue_random(300, $urandom());
    drain();

    set_policy($urandom_range(0, 254), $urandom_range(1, 1048575), $urandom_range(1, 8));
    queue_random(300, $urandom());
    drain();

    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d violations recorded, %0d disconnects, 7 policy settings",
             results_seen, viol_seen, disc_seen);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
